// ===== hw/rtl/hpra_pkg.sv =====
// shared types and constants for the half precision residual adder
// no dependencies
`default_nettype none
package hpra_pkg;
	localparam int HalfW = 16;
	localparam int MagW  = 41;
	localparam int LzW   = 6;
	localparam int SigW  = 11;
	localparam int ShW   = 5;

	localparam logic [HalfW-1:0] HALF_QNAN = 16'h7E00;
	localparam logic [HalfW-2:0] HALF_INF  = 15'h7C00;
	localparam logic [4:0]       HALF_EMAX = 5'h1F;

	typedef struct packed {
		logic nan;
		logic inf;
		logic inf_sign;
	} spec_t;

	typedef struct packed {
		logic            sign;
		logic [MagW-1:0] mag;
	} smag_t;
endpackage
`default_nettype wire

// ===== hw/rtl/hpra_unpack.sv =====
// stage 1: decode both halves, flag specials, place magnitudes in fixed point
// depends on hpra_pkg
`default_nettype none
module hpra_unpack (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     valid,
	input  wire logic [hpra_pkg::HalfW-1:0] operand_a,
	input  wire logic [hpra_pkg::HalfW-1:0] operand_b,
	output logic                          valid_s1,
	output hpra_pkg::smag_t               a_s1,
	output hpra_pkg::smag_t               b_s1,
	output hpra_pkg::spec_t               spec_s1
);
	import hpra_pkg::*;

	// fixed point with lsb worth 2^-24
	function automatic smag_t to_fixed(input logic [HalfW-1:0] h);
		logic [SigW-1:0] sig;
		logic [ShW-1:0]  sh;
		smag_t           r;
		sig = {h[14:10] != 5'd0, h[9:0]};
		sh  = (h[14:10] == 5'd0) ? 5'd0 : h[14:10] - 5'd1;
		r.sign = h[15];
		r.mag  = {{(MagW-SigW){1'b0}}, sig} << sh;
		return r;
	endfunction

	logic  a_nan, b_nan, a_inf, b_inf;
	spec_t spec;

	always_comb begin
		a_nan = (operand_a[14:10] == HALF_EMAX) && (operand_a[9:0] != 10'd0);
		b_nan = (operand_b[14:10] == HALF_EMAX) && (operand_b[9:0] != 10'd0);
		a_inf = (operand_a[14:10] == HALF_EMAX) && (operand_a[9:0] == 10'd0);
		b_inf = (operand_b[14:10] == HALF_EMAX) && (operand_b[9:0] == 10'd0);
		spec.nan = a_nan || b_nan || (a_inf && b_inf && (operand_a[15] != operand_b[15]));
		spec.inf = a_inf || b_inf;
		spec.inf_sign = a_inf ? operand_a[15] : operand_b[15];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= to_fixed(operand_a);
			b_s1    <= to_fixed(operand_b);
			spec_s1 <= spec;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/hpra_addsub.sv =====
// stage 2: exact signed add of the two fixed point magnitudes
// depends on hpra_pkg
`default_nettype none
module hpra_addsub (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         valid_s1,
	input  hpra_pkg::smag_t   a_s1,
	input  hpra_pkg::smag_t   b_s1,
	input  hpra_pkg::spec_t   spec_s1,
	output logic              valid_s2,
	output hpra_pkg::smag_t   sum_s2,
	output hpra_pkg::spec_t   spec_s2
);
	import hpra_pkg::*;

	smag_t sum;

	// exact cancellation gives +0, -0 + -0 keeps its sign
	always_comb begin
		if (a_s1.sign == b_s1.sign) begin
			sum.mag  = a_s1.mag + b_s1.mag;
			sum.sign = a_s1.sign;
		end else if (a_s1.mag >= b_s1.mag) begin
			sum.mag  = a_s1.mag - b_s1.mag;
			sum.sign = a_s1.sign && (a_s1.mag != b_s1.mag);
		end else begin
			sum.mag  = b_s1.mag - a_s1.mag;
			sum.sign = b_s1.sign;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= sum;
			spec_s2 <= spec_s1;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/hpra_lzc.sv =====
// stage 3: leading zero count, stage 4: normalizing shift
// depends on hpra_pkg
`default_nettype none
module hpra_lzc (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    valid_s2,
	input  hpra_pkg::smag_t              sum_s2,
	input  hpra_pkg::spec_t              spec_s2,
	output logic                         valid_s4,
	output logic                         sign_s4,
	output logic                         zero_s4,
	output logic [hpra_pkg::LzW-1:0]     lz_s4,
	output logic [hpra_pkg::MagW-1:0]    norm_s4,
	output hpra_pkg::spec_t              spec_s4
);
	import hpra_pkg::*;

	logic [LzW-1:0] lz;
	logic           valid_s3;
	smag_t          sum_s3;
	spec_t          spec_s3;
	logic [LzW-1:0] lz_s3;

	always_comb begin
		lz = LzW'(MagW);
		for (int i = 0; i < MagW; i++) begin
			if (sum_s2.mag[i]) begin
				lz = LzW'(MagW - 1 - i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= sum_s2;
			spec_s3 <= spec_s2;
			lz_s3   <= lz;
			sign_s4 <= sum_s3.sign;
			zero_s4 <= (sum_s3.mag == '0);
			lz_s4   <= lz_s3;
			norm_s4 <= sum_s3.mag << lz_s3;
			spec_s4 <= spec_s3;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/hpra_round.sv =====
// stage 5: round to a 24 bit significand (nearest even), narrow to half by truncation
// depends on hpra_pkg
`default_nettype none
module hpra_round (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     valid_s4,
	input  wire logic                     sign_s4,
	input  wire logic                     zero_s4,
	input  wire logic [hpra_pkg::LzW-1:0]  lz_s4,
	input  wire logic [hpra_pkg::MagW-1:0] norm_s4,
	input  hpra_pkg::spec_t               spec_s4,
	output logic                          valid_s5,
	output logic [hpra_pkg::HalfW-1:0]    sum_s5
);
	import hpra_pkg::*;

	logic              up;
	logic [24:0]       sig;
	logic              carry;
	logic signed [6:0] he;
	logic [HalfW-1:0]  res;

	always_comb begin
		up    = norm_s4[16] && ((|norm_s4[15:0]) || norm_s4[17]);
		sig   = {1'b0, norm_s4[MagW-1:17]} + {24'd0, up};
		carry = sig[24];
		// leading one at bit 40 means a half exponent of 31
		he    = 7'sd31 - $signed({1'b0, lz_s4}) + $signed({6'd0, carry});
		if (spec_s4.nan) begin
			res = HALF_QNAN;
		end else if (spec_s4.inf) begin
			res = {spec_s4.inf_sign, HALF_INF};
		end else if (zero_s4 || he <= 7'sd0) begin
			res = {sign_s4, 15'd0};
		end else if (he >= 7'sd31) begin
			res = {sign_s4, HALF_INF};
		end else begin
			res = {sign_s4, he[4:0], carry ? 10'd0 : sig[22:13]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5 <= res;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/half_precision_residual_add.sv =====
// half precision add through an exact fixed point sum, five register stages
// throughput: one item per cycle while the pipeline is not held
// the whole pipeline holds while a finished item waits at the output
// reset (arst_n low, asynchronous) clears all valid bits; data registers are not reset
// depends on hpra_pkg and the hpra stage modules
`default_nettype none
module half_precision_residual_add (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [hpra_pkg::HalfW-1:0] operand_a,
	input  wire logic [hpra_pkg::HalfW-1:0] operand_b,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [hpra_pkg::HalfW-1:0]      sum_bits
);
	import hpra_pkg::*;

	logic             en;
	logic             valid_s1, valid_s2, valid_s4, valid_s5;
	smag_t            a_s1, b_s1, sum_s2;
	spec_t            spec_s1, spec_s2, spec_s4;
	logic             sign_s4, zero_s4;
	logic [LzW-1:0]   lz_s4;
	logic [MagW-1:0]  norm_s4;
	logic [HalfW-1:0] sum_s5;

	assign en        = !(valid_s5 && out_stall);
	assign in_stall  = !en;
	assign out_valid = valid_s5;
	assign sum_bits  = sum_s5;

	hpra_unpack u_unpack (
		.clk, .arst_n, .en, .valid(in_valid), .operand_a, .operand_b,
		.valid_s1, .a_s1, .b_s1, .spec_s1
	);

	hpra_addsub u_addsub (
		.clk, .arst_n, .en, .valid_s1, .a_s1, .b_s1, .spec_s1,
		.valid_s2, .sum_s2, .spec_s2
	);

	hpra_lzc u_lzc (
		.clk, .arst_n, .en, .valid_s2, .sum_s2, .spec_s2,
		.valid_s4, .sign_s4, .zero_s4, .lz_s4, .norm_s4, .spec_s4
	);

	hpra_round u_round (
		.clk, .arst_n, .en, .valid_s4, .sign_s4, .zero_s4, .lz_s4, .norm_s4, .spec_s4,
		.valid_s5, .sum_s5
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output stage");

	a_only_quiet_nan: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sum_bits[14:10] == HALF_EMAX && sum_bits[9:0] != 10'd0)
		|-> sum_bits == HALF_QNAN)
		else $error("nan result is not the canonical quiet nan");

	a_no_subnormal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sum_bits[14:10] == 5'd0) |-> sum_bits[9:0] == 10'd0)
		else $error("subnormal result produced");
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for half_precision_residual_add: directed table, then random items
// depends on hpra_pkg and the half_precision_residual_add rtl
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import hpra_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int DrainCycles = 20;
	localparam int RandomItems = 1830;

	typedef struct packed {
		logic [HalfW-1:0] a;
		logic [HalfW-1:0] b;
		logic             fixed;
		logic [HalfW-1:0] sum;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [HalfW-1:0] operand_a = '0;
	logic [HalfW-1:0] operand_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [HalfW-1:0] sum_bits;

	// typed expectation travels with the item
	logic             row_fixed = 1'b0;
	logic [HalfW-1:0] row_sum = '0;

	logic [HalfW-1:0] pending_sums[$];
	int errors = 0;
	int cycles = 0;
	int accepted = 0;
	int checked = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	logic hold_req = 1'b0;

	half_precision_residual_add dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_stall(out_stall),
		.sum_bits(sum_bits)
	);

	always #2 clk = ~clk;

	// exact fixed point sum in units of 2^-24, rounded to single, truncated to half
	function automatic logic [HalfW-1:0] half_sum_truncated(logic [HalfW-1:0] a,
			logic [HalfW-1:0] b);
		longint ma, mb, s, m, keep, rem, halfway;
		int p, sh, he;
		logic sg, a_spec, b_spec;
		a_spec = (a[14:10] == HALF_EMAX);
		b_spec = (b[14:10] == HALF_EMAX);
		if ((a_spec && a[9:0] != 0) || (b_spec && b[9:0] != 0) ||
				(a_spec && b_spec && a[15] != b[15]))
			return HALF_QNAN;
		if (a_spec)
			return {a[15], HALF_INF};
		if (b_spec)
			return {b[15], HALF_INF};
		ma = (a[14:10] == 0) ? longint'(a[9:0]) : longint'({1'b1, a[9:0]}) << (a[14:10] - 1);
		mb = (b[14:10] == 0) ? longint'(b[9:0]) : longint'({1'b1, b[9:0]}) << (b[14:10] - 1);
		s = (a[15] ? -ma : ma) + (b[15] ? -mb : mb);
		if (s == 0)
			return {a[15] & b[15], 15'h0};
		sg = (s < 0);
		m = sg ? -s : s;
		p = 0;
		for (int i = 0; i < 48; i++)
			if (m[i])
				p = i;
		sh = p - 23;
		if (sh > 0) begin
			keep = m >> sh;
			rem = m & ((64'sd1 << sh) - 1);
			halfway = 64'sd1 << (sh - 1);
			if (rem > halfway || (rem == halfway && keep[0]))
				keep++;
			if (keep == (64'sd1 << 24)) begin
				keep = keep >> 1;
				sh++;
			end
		end else begin
			keep = m << (-sh);
		end
		he = sh - 1 + 15;
		if (he <= 0)
			return {sg, 15'h0};
		if (he >= 31)
			return {sg, HALF_INF};
		return {sg, he[4:0], keep[22:13]};
	endfunction

	function automatic logic [HalfW-1:0] random_half();
		logic [HalfW-1:0] h;
		h = HalfW'($urandom);
		case ($urandom_range(0, 5))
			0: h[14:10] = 5'h00;
			1: h[14:10] = 5'h1F;
			2: h[14:10] = 5'($urandom_range(1, 3));
			default: ;
		endcase
		return h;
	endfunction

	task automatic report_mismatch(input string what, input logic [HalfW-1:0] got,
			input logic [HalfW-1:0] want);
		$display("mismatch %s: sum_bits got %h expected %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	task automatic send_item(input logic [HalfW-1:0] a, input logic [HalfW-1:0] b,
			input logic fixed, input logic [HalfW-1:0] sum);
		if (sender_idle_pct > 0)
			while ($urandom_range(0, 99) < sender_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		operand_a <= a;
		operand_b <= b;
		row_fixed <= fixed;
		row_sum <= sum;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_sums.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench: FAIL");
			$finish;
		end
	end

	// expectation recorded when the item is accepted
	always @(posedge clk)
		if (arst_n && in_valid && !in_stall) begin
			pending_sums.push_back(row_fixed ? row_sum : half_sum_truncated(operand_a, operand_b));
			accepted++;
		end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sums.size() == 0) begin
				report_mismatch("unexpected item", sum_bits, '0);
			end else begin
				if (sum_bits !== pending_sums[0])
					report_mismatch("sum", sum_bits, pending_sums[0]);
				void'(pending_sums.pop_front());
				checked++;
			end
		end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_cycles;
		logic hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				hold_cycles = 0;
				while (hold_cycles < 200) begin
					@(posedge clk);
					hold_cycles++;
				end
				hold_done = 1'b1;
			end
			out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
		end
	end

	initial begin
		row_t rows[$];
		logic [HalfW-1:0] a, b;
		int phase_items;
		rows = '{
			'{16'h0000, 16'h0000, 1'b1, 16'h0000},
			'{16'h8000, 16'h8000, 1'b1, 16'h8000},
			'{16'h8000, 16'h0000, 1'b1, 16'h0000},
			'{16'h7C00, 16'hFC00, 1'b1, 16'h7E00},
			'{16'h7E00, 16'h0000, 1'b1, 16'h7E00},
			'{16'h7C01, 16'h3C00, 1'b1, 16'h7E00},
			'{16'hFFFF, 16'hFFFF, 1'b1, 16'h7E00},
			'{16'h7C00, 16'h3C00, 1'b1, 16'h7C00},
			'{16'hFC00, 16'h7BFF, 1'b1, 16'hFC00},
			'{16'h7C00, 16'h7C00, 1'b1, 16'h7C00},
			'{16'h7BFF, 16'h7BFF, 1'b1, 16'h7C00},
			'{16'hFBFF, 16'hFBFF, 1'b1, 16'hFC00},
			'{16'h0001, 16'h0001, 1'b1, 16'h0000},
			'{16'h8001, 16'h8000, 1'b1, 16'h8000},
			'{16'h0400, 16'h8001, 1'b1, 16'h0000},
			'{16'h3C00, 16'hBC00, 1'b1, 16'h0000},
			'{16'h3C00, 16'h3C00, 1'b1, 16'h4000},
			'{16'h0200, 16'h0200, 1'b1, 16'h0400},
			'{16'h3C00, 16'h0001, 1'b0, 16'h0000},
			'{16'h3C00, 16'h1001, 1'b0, 16'h0000},
			'{16'h3BFF, 16'h0C00, 1'b0, 16'h0000},
			'{16'h03FF, 16'h03FF, 1'b0, 16'h0000},
			'{16'h5555, 16'hAAAA, 1'b0, 16'h0000},
			'{16'h7BFF, 16'hFBFE, 1'b0, 16'h0000}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_item(rows[i].a, rows[i].b, rows[i].fixed, rows[i].sum);
		// long hold-off while items keep coming, so the pipeline backs up
		hold_req <= 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct = (phase == 1) ? 66 : (phase == 3) ? 11 : 0;
			receiver_stall_pct = (phase == 2) ? 66 : (phase == 3) ? 11 : 0;
			phase_items = RandomItems / 4;
			for (int n = 0; n < phase_items; n++) begin
				a = random_half();
				if ($urandom_range(0, 1)) begin
					// nearby exponents exercise cancellation and rounding carries
					b = HalfW'($urandom);
					b[14:10] = a[14:10] ^ 5'($urandom_range(0, 3));
				end else begin
					b = random_half();
				end
				send_item(a, b, 1'b0, '0);
			end
			// sender waits for every result before the next phase
			drain();
		end
		receiver_stall_pct = 0;
		drain();
		repeat (DrainCycles) @(posedge clk);
		$display("covered %0d items (%0d checked) over four idle/stall phases", accepted, checked);
		$display("including specials, overflow, underflow and a long output hold-off");
		if (errors == 0 && pending_sums.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/hpra_pkg.sv
hw/rtl/hpra_unpack.sv
hw/rtl/hpra_addsub.sv
hw/rtl/hpra_lzc.sv
hw/rtl/hpra_round.sv
hw/rtl/half_precision_residual_add.sv
test/testbench.sv
